>>> design/lfoa_pkg.sv
// ----------------------------------------------------------------------------
// lfoa_pkg
// Shared types and constants of the lidar front obstacle aggregator: widths,
// angle constants, register indexes, table entry and table command layout.
// ----------------------------------------------------------------------------
package lfoa_pkg;

    localparam int LABEL_W = 8;
    localparam int YAW_W   = 16;
    localparam int DIST_W  = 16;
    localparam int COUNT_W = 9;
    localparam int ANGLE_W = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // angles in hundredths of a degree
    localparam logic [YAW_W-1:0] FULL_TURN = 16'd36000;
    localparam logic [YAW_W-1:0] HALF_TURN = 16'd18000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_ANGLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST  = 1'd1;

    localparam logic [ANGLE_W-1:0] HALF_ANGLE_RST = 15'd4500;
    localparam logic [DIST_W-1:0]  STOP_DIST_RST  = 16'd50;

    // one per-label table entry
    typedef struct packed {
        logic [COUNT_W-1:0] total_count;
        logic [COUNT_W-1:0] front_count;
        logic [DIST_W-1:0]  closest_distance;
        logic [DIST_W-1:0]  closest_front_distance;
        logic [YAW_W-1:0]   closest_front_yaw;
    } entry_t;

    // table access for one cycle
    typedef struct packed {
        logic               rd_en;
        logic [LABEL_W-1:0] rd_addr;
        logic               wr_en;
        logic [LABEL_W-1:0] wr_addr;
        logic               clr_all;
    } tbl_cmd_t;

endpackage

>>> design/lfoa_table.sv
// ----------------------------------------------------------------------------
// lfoa_table
// Per-label table: synchronous memory with one read and one write port,
// valid flags in flops, and the merge of one ray into a read entry.
// ----------------------------------------------------------------------------
module lfoa_table #(
    parameter int SLOTS    = 256,
    parameter int MAX_RAYS = 360
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfoa_pkg::tbl_cmd_t          cmd,
    input  logic [lfoa_pkg::YAW_W-1:0]  ray_yaw,
    input  logic [lfoa_pkg::DIST_W-1:0] ray_distance,
    input  logic                        ray_front,
    output lfoa_pkg::entry_t            rd_entry,
    output logic                        rd_valid
);
    import lfoa_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_RAYS < 511) ? COUNT_W'(MAX_RAYS) : 9'd511;

    entry_t            mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    entry_t            rd_data_reg;
    logic              rd_vld_reg;
    entry_t            merged;
    logic [IW-1:0]     rd_idx;
    logic [IW-1:0]     wr_idx;

    assign rd_idx = cmd.rd_addr[IW-1:0];
    assign wr_idx = cmd.wr_addr[IW-1:0];

    // merge the ray into the entry read in the previous cycle
    always_comb
    begin
        merged = rd_data_reg;
        if (!rd_vld_reg)
        begin
            merged.total_count            = COUNT_W'(1);
            merged.front_count            = ray_front ? COUNT_W'(1) : '0;
            merged.closest_distance       = ray_distance;
            merged.closest_front_distance = ray_front ? ray_distance : '0;
            merged.closest_front_yaw      = ray_front ? ray_yaw : '0;
        end
        else
        begin
            if (rd_data_reg.total_count < COUNT_CAP)
                merged.total_count = rd_data_reg.total_count + 1'b1;
            else
                merged.total_count = COUNT_CAP;
            if (ray_front)
            begin
                if (rd_data_reg.front_count < COUNT_CAP)
                    merged.front_count = rd_data_reg.front_count + 1'b1;
                else
                    merged.front_count = COUNT_CAP;
                if (rd_data_reg.closest_front_distance == '0 ||
                    ray_distance < rd_data_reg.closest_front_distance)
                begin
                    merged.closest_front_distance = ray_distance;
                    merged.closest_front_yaw      = ray_yaw;
                end
            end
            if (ray_distance < rd_data_reg.closest_distance)
                merged.closest_distance = ray_distance;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_idx] <= merged;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    // valid flags, cleared at once at scan end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_all)
                valid_reg <= '0;
            else if (cmd.wr_en)
                valid_reg[wr_idx] <= 1'b1;
            if (cmd.rd_en)
                rd_vld_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_entry = rd_data_reg;
    assign rd_valid = rd_vld_reg;

endmodule

>>> design/lidar_front_obstacle_aggregator.sv
// ----------------------------------------------------------------------------
// lidar_front_obstacle_aggregator
// Collects lidar returns per object label and reports, at each scan end, the
// object with the closest frontal return and whether it is inside stop range.
// ----------------------------------------------------------------------------
// A ray that does not end a scan has its label's table entry read from the
// synchronous memory, then is merged into that entry and written back. A ray
// with scan_end set is merged as well; then the table is walked at one entry
// per memory read, the last compare is finished in ST_LAST and the result
// register is loaded in ST_REPORT, which waits while that register still
// holds an untaken result. The result register lets the next ray be taken
// while a result waits. Valid flags are all cleared together at scan end, so
// no clearing pass is needed after reset. Configuration writes are taken at
// any time (cfg_ready is always high).
module lidar_front_obstacle_aggregator #(
    parameter int OBJECT_SLOTS = 256,
    parameter int MAX_RAYS     = 360
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // ray channel
    input  logic                             ray_valid,
    output logic                             ray_stall,
    input  logic [lfoa_pkg::LABEL_W-1:0]     object_label,
    input  logic [lfoa_pkg::YAW_W-1:0]       ray_yaw,
    input  logic [lfoa_pkg::DIST_W-1:0]      ray_distance,
    input  logic                             ray_hit,
    input  logic                             scan_end,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic                             found,
    output logic [lfoa_pkg::LABEL_W-1:0]     nearest_label,
    output logic [lfoa_pkg::DIST_W-1:0]      front_distance,
    output logic [lfoa_pkg::YAW_W-1:0]       front_yaw,
    output logic [lfoa_pkg::DIST_W-1:0]      overall_distance,
    output logic [lfoa_pkg::COUNT_W-1:0]     total_rays,
    output logic [lfoa_pkg::COUNT_W-1:0]     front_rays,
    output logic                             stop,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfoa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfoa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lfoa_pkg::*;

    // labels are 8 bits wide, so at most 256 slots can ever be addressed
    localparam int SLOTS = (OBJECT_SLOTS < 256) ? OBJECT_SLOTS : 256;
    localparam int IW    = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_WALK,
        ST_LAST,
        ST_REPORT
    } state_t;

    state_t               state_reg, state_next;
    logic [ANGLE_W-1:0]   half_angle_reg, half_angle_next;
    logic [DIST_W-1:0]    stop_dist_reg, stop_dist_next;

    logic [LABEL_W-1:0]   item_label_reg, item_label_next;
    logic [YAW_W-1:0]     item_yaw_reg, item_yaw_next;
    logic [DIST_W-1:0]    item_dist_reg, item_dist_next;
    logic                 item_apply_reg, item_apply_next;
    logic                 item_end_reg, item_end_next;
    logic                 item_front_reg, item_front_next;

    logic [IW-1:0]        walk_idx_reg, walk_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 best_found_reg, best_found_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    entry_t               best_reg, best_next;

    logic                 res_valid_reg, res_valid_next;
    logic                 res_found_reg, res_found_next;
    logic [LABEL_W-1:0]   res_label_reg, res_label_next;
    entry_t               res_entry_reg, res_entry_next;
    logic                 res_stop_reg, res_stop_next;

    logic                 ray_accept;
    logic                 res_free;
    logic [YAW_W-1:0]     yaw_mod;
    logic [YAW_W-1:0]     yaw_mag;
    logic                 ray_is_front;
    logic                 label_in_range;
    logic                 cand_ok;
    tbl_cmd_t             tbl_cmd;
    entry_t               tbl_entry;
    logic                 tbl_valid;

    assign ray_stall  = (state_reg != ST_IDLE);
    assign ray_accept = ray_valid && !ray_stall;
    assign res_free   = !res_valid_reg || !result_stall;
    assign cfg_ready  = 1'b1;

    // frontal test: fold yaw into one turn, then into -180..180 magnitude
    always_comb
    begin
        yaw_mod = (ray_yaw >= FULL_TURN) ? (ray_yaw - FULL_TURN) : ray_yaw;
        yaw_mag = (yaw_mod > HALF_TURN) ? (FULL_TURN - yaw_mod) : yaw_mod;
        ray_is_front = (yaw_mag <= {1'b0, half_angle_reg});
        label_in_range = ({1'b0, object_label} < 9'(SLOTS));
    end

    // walk candidate against the best so far; ties go to the smaller overall distance, then the earlier label
    assign cand_ok = tbl_valid && (tbl_entry.front_count != '0) &&
                     (tbl_entry.closest_front_distance != '0) &&
                     (!best_found_reg ||
                      (tbl_entry.closest_front_distance < best_reg.closest_front_distance) ||
                      ((tbl_entry.closest_front_distance == best_reg.closest_front_distance) &&
                       (tbl_entry.closest_distance < best_reg.closest_distance)));

    // table access
    always_comb
    begin
        tbl_cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                tbl_cmd.rd_en   = ray_accept;
                tbl_cmd.rd_addr = object_label;
            end
            ST_UPDATE:
            begin
                tbl_cmd.wr_en   = item_apply_reg;
                tbl_cmd.wr_addr = item_label_reg;
            end
            ST_WALK:
            begin
                tbl_cmd.rd_en   = 1'b1;
                tbl_cmd.rd_addr = LABEL_W'(walk_idx_reg);
            end
            ST_LAST:
            begin
                tbl_cmd.rd_en = 1'b0;
            end
            ST_REPORT:
            begin
                tbl_cmd.clr_all = res_free;
            end
            default:
            begin
                tbl_cmd = '0;
            end
        endcase
    end

    lfoa_table #(
        .SLOTS    (SLOTS),
        .MAX_RAYS (MAX_RAYS)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (tbl_cmd),
        .ray_yaw      (item_yaw_reg),
        .ray_distance (item_dist_reg),
        .ray_front    (item_front_reg),
        .rd_entry     (tbl_entry),
        .rd_valid     (tbl_valid)
    );

    // next-state and datapath
    always_comb
    begin
        state_next      = state_reg;
        half_angle_next = half_angle_reg;
        stop_dist_next  = stop_dist_reg;
        item_label_next = item_label_reg;
        item_yaw_next   = item_yaw_reg;
        item_dist_next  = item_dist_reg;
        item_apply_next = item_apply_reg;
        item_end_next   = item_end_reg;
        item_front_next = item_front_reg;
        walk_idx_next   = walk_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = walk_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_valid_next  = res_valid_reg;
        res_found_next  = res_found_reg;
        res_label_next  = res_label_reg;
        res_entry_next  = res_entry_reg;
        res_stop_next   = res_stop_reg;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF_ANGLE: half_angle_next = cfg_data[ANGLE_W-1:0];
                CFG_STOP_DIST:  stop_dist_next  = cfg_data;
                default:        half_angle_next = half_angle_reg;
            endcase
        end

        // result transaction taken
        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        // running compare of the entry read in the previous walk cycle
        if (cmp_vld_reg && cand_ok)
        begin
            best_found_next = 1'b1;
            best_idx_next   = cmp_idx_reg;
            best_next       = tbl_entry;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ray_accept)
                begin
                    item_label_next = object_label;
                    item_yaw_next   = ray_yaw;
                    item_dist_next  = ray_distance;
                    item_apply_next = ray_hit && label_in_range;
                    item_end_next   = scan_end;
                    item_front_next = ray_is_front;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                walk_idx_next   = '0;
                best_found_next = 1'b0;
                state_next      = item_end_reg ? ST_WALK : ST_IDLE;
            end
            ST_WALK:
            begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = walk_idx_reg;
                if (walk_idx_reg == LAST_IDX)
                    state_next = ST_LAST;
                else
                    walk_idx_next = walk_idx_reg + 1'b1;
            end
            ST_LAST:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_found_next = best_found_reg;
                    if (best_found_reg)
                    begin
                        res_label_next = LABEL_W'(best_idx_reg);
                        res_entry_next = best_reg;
                        res_stop_next  = (best_reg.closest_front_distance <= stop_dist_reg);
                    end
                    else
                    begin
                        res_label_next = '0;
                        res_entry_next = '0;
                        res_stop_next  = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, registers and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            half_angle_reg <= HALF_ANGLE_RST;
            stop_dist_reg  <= STOP_DIST_RST;
            item_apply_reg <= 1'b0;
            item_end_reg   <= 1'b0;
            walk_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            half_angle_reg <= half_angle_next;
            stop_dist_reg  <= stop_dist_next;
            item_apply_reg <= item_apply_next;
            item_end_reg   <= item_end_next;
            walk_idx_reg   <= walk_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            best_found_reg <= best_found_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_label_reg <= item_label_next;
        item_yaw_reg   <= item_yaw_next;
        item_dist_reg  <= item_dist_next;
        item_front_reg <= item_front_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_found_reg  <= res_found_next;
        res_label_reg  <= res_label_next;
        res_entry_reg  <= res_entry_next;
        res_stop_reg   <= res_stop_next;
    end

    assign result_valid     = res_valid_reg;
    assign found            = res_found_reg;
    assign nearest_label    = res_label_reg;
    assign front_distance   = res_entry_reg.closest_front_distance;
    assign front_yaw        = res_entry_reg.closest_front_yaw;
    assign overall_distance = res_entry_reg.closest_distance;
    assign total_rays       = res_entry_reg.total_count;
    assign front_rays       = res_entry_reg.front_count;
    assign stop             = res_stop_reg;

    // stop is only raised for a found object
    a_stop_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && stop |-> found)
        else $error("stop without a found object");

    // an empty result carries zero label, frontal distance and ray counts
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> (nearest_label == '0) && (front_distance == '0) &&
                                   (total_rays == '0) && (front_rays == '0))
        else $error("empty result with nonzero fields");

    // a reported object has a frontal hit with a positive distance
    a_found_front: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> (front_distance != '0) && (front_rays != '0) &&
                                  (front_rays <= total_rays))
        else $error("reported object without a valid frontal hit");

    // an accepted ray is merged in the next cycle
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && !ray_stall |=> state_reg == ST_UPDATE)
        else $error("accepted ray not followed by table update");

    // the result register is only loaded when it is free
    a_report_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPORT && res_valid_reg && result_stall |=> state_reg == ST_REPORT)
        else $error("result loaded over a pending transaction");

endmodule

>>> tb/sv/tb_lidar_front_obstacle_aggregator.sv
// ----------------------------------------------------------------------------
// tb_lidar_front_obstacle_aggregator
// Self-checking bench for the lidar front obstacle aggregator. Rays are fed
// through a queue-driven driver. A per-label obstacle tracker predicts the
// report of every scan end, and each report taken from the result channel is
// compared field by field. The bench walks through several register
// settings and sender/receiver idle mixes. It also runs a saturation scan and
// a mid-phase pause that holds the sender until all reports are in.
// ----------------------------------------------------------------------------
module tb_lidar_front_obstacle_aggregator;
    timeunit 1ns;
    timeprecision 1ps;

    import lfoa_pkg::*;

    localparam int COUNT_CAP     = 360;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_RAYS    = 20;
    localparam bit [15:0] YAW_CORNERS [8] = '{16'd0, 16'd1, 16'd17999, 16'd18000,
                                              16'd18001, 16'd35999, 16'd36000, 16'hFFFF};

    // one ray transaction
    typedef struct {
        bit [7:0]  label;
        bit [15:0] yaw;
        bit [15:0] distance;
        bit        hit;
        bit        last;
    } ray_t;

    // per-label obstacle record
    typedef struct {
        bit        used;
        bit [8:0]  total;
        bit [8:0]  frontal;
        bit [15:0] near_dist;
        bit [15:0] front_dist;
        bit [15:0] front_yaw;
    } obstacle_t;

    // one scan report
    typedef struct packed {
        bit        found;
        bit [7:0]  label;
        bit [15:0] front_dist;
        bit [15:0] front_yaw;
        bit [15:0] near_dist;
        bit [8:0]  total;
        bit [8:0]  frontal;
        bit        stop;
    } scan_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        ray_valid = 1'b0;
    logic        ray_stall;
    logic [7:0]  object_label = '0;
    logic [15:0] ray_yaw = '0;
    logic [15:0] ray_distance = '0;
    logic        ray_hit = 1'b0;
    logic        scan_end = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        found;
    logic [7:0]  nearest_label;
    logic [15:0] front_distance;
    logic [15:0] front_yaw;
    logic [15:0] overall_distance;
    logic [8:0]  total_rays;
    logic [8:0]  front_rays;
    logic        stop;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ray_t         pending_rays[$];
    ray_t         next_ray;
    scan_report_t scan_reports[$];
    scan_report_t oldest_report;
    obstacle_t    obstacles[256];

    bit [14:0] half_angle = HALF_ANGLE_RST;
    bit [15:0] stop_limit = STOP_DIST_RST;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int reports_checked = 0;
    int rays_sent = 0;
    int scans_sent = 0;
    int quiet_cycles = 0;

    lidar_front_obstacle_aggregator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .ray_valid        (ray_valid),
        .ray_stall        (ray_stall),
        .object_label     (object_label),
        .ray_yaw          (ray_yaw),
        .ray_distance     (ray_distance),
        .ray_hit          (ray_hit),
        .scan_end         (scan_end),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .found            (found),
        .nearest_label    (nearest_label),
        .front_distance   (front_distance),
        .front_yaw        (front_yaw),
        .overall_distance (overall_distance),
        .total_rays       (total_rays),
        .front_rays       (front_rays),
        .stop             (stop),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // frontal test on the yaw folded into -180..+180 degrees
    function automatic bit in_front(input bit [15:0] yaw);
        int unsigned folded;
        int unsigned magnitude;
        folded = yaw % int'(FULL_TURN);
        magnitude = (folded > int'(HALF_TURN)) ? int'(FULL_TURN) - folded : folded;
        return magnitude <= half_angle;
    endfunction

    function automatic bit [8:0] count_up(input bit [8:0] count);
        return (count < COUNT_CAP) ? count + 9'd1 : 9'(COUNT_CAP);
    endfunction

    // tracker update for one accepted ray, report on scan end
    task automatic track_ray(input ray_t ray);
        bit           fr;
        bit           any;
        scan_report_t rep;
        fr = in_front(ray.yaw);
        if (ray.hit)
        begin
            if (!obstacles[ray.label].used)
            begin
                obstacles[ray.label].used       = 1'b1;
                obstacles[ray.label].total      = 9'd1;
                obstacles[ray.label].frontal    = fr ? 9'd1 : 9'd0;
                obstacles[ray.label].near_dist  = ray.distance;
                obstacles[ray.label].front_dist = fr ? ray.distance : 16'd0;
                obstacles[ray.label].front_yaw  = fr ? ray.yaw : 16'd0;
            end
            else
            begin
                obstacles[ray.label].total = count_up(obstacles[ray.label].total);
                if (fr)
                begin
                    obstacles[ray.label].frontal = count_up(obstacles[ray.label].frontal);
                    // a zero frontal distance is always replaced
                    if (obstacles[ray.label].front_dist == 0
                        || ray.distance < obstacles[ray.label].front_dist)
                    begin
                        obstacles[ray.label].front_dist = ray.distance;
                        obstacles[ray.label].front_yaw  = ray.yaw;
                    end
                end
                if (ray.distance < obstacles[ray.label].near_dist)
                    obstacles[ray.label].near_dist = ray.distance;
            end
        end
        if (ray.last)
        begin
            rep = '0;
            any = 1'b0;
            // walk in label order, ties go to smaller overall distance then lower label
            for (int i = 0; i < 256; i++)
            begin
                if (obstacles[i].used && obstacles[i].frontal != 0
                    && obstacles[i].front_dist != 0)
                begin
                    if (!any || obstacles[i].front_dist < rep.front_dist
                        || (obstacles[i].front_dist == rep.front_dist
                            && obstacles[i].near_dist < rep.near_dist))
                    begin
                        any            = 1'b1;
                        rep.found      = 1'b1;
                        rep.label      = 8'(i);
                        rep.front_dist = obstacles[i].front_dist;
                        rep.front_yaw  = obstacles[i].front_yaw;
                        rep.near_dist  = obstacles[i].near_dist;
                        rep.total      = obstacles[i].total;
                        rep.frontal    = obstacles[i].frontal;
                    end
                end
                obstacles[i].used = 1'b0;
            end
            rep.stop = rep.found && (rep.front_dist <= stop_limit);
            scan_reports.push_back(rep);
        end
    endtask

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // ray driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ray_valid <= 1'b0;
        else if (!ray_valid || !ray_stall)
        begin
            if (pending_rays.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_ray = pending_rays.pop_front();
                object_label <= next_ray.label;
                ray_yaw      <= next_ray.yaw;
                ray_distance <= next_ray.distance;
                ray_hit      <= next_ray.hit;
                scan_end     <= next_ray.last;
                ray_valid    <= 1'b1;
            end
            else
                ray_valid <= 1'b0;
        end
    end

    // ray monitor feeding the tracker
    always @(posedge clk)
    begin
        if (rst_n && ray_valid && !ray_stall)
            track_ray('{object_label, ray_yaw, ray_distance, ray_hit, scan_end});
    end

    // result stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (scan_reports.size() == 0)
            begin
                errors++;
                $display("%0t: report with no scan end pending, label %0d",
                         $time, nearest_label);
            end
            else
            begin
                oldest_report = scan_reports.pop_front();
                reports_checked++;
                check_field("found", oldest_report.found, found);
                check_field("nearest_label", oldest_report.label, nearest_label);
                check_field("front_distance", oldest_report.front_dist, front_distance);
                check_field("front_yaw", oldest_report.front_yaw, front_yaw);
                check_field("overall_distance", oldest_report.near_dist, overall_distance);
                check_field("total_rays", oldest_report.total, total_rays);
                check_field("front_rays", oldest_report.frontal, front_rays);
                check_field("stop", oldest_report.stop, stop);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((ray_valid && !ray_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transaction", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_ray(input bit [7:0] label, input bit [15:0] yaw,
                             input bit [15:0] distance, input bit hit, input bit last);
        pending_rays.push_back('{label, yaw, distance, hit, last});
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    // write both registers back to back, valid held high between them
    task automatic set_config(input bit [15:0] half_word, input bit [15:0] stop_word);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HALF_ANGLE;
        cfg_data  <= half_word;
        do @(posedge clk); while (!cfg_ready);
        half_angle = half_word[14:0];
        cfg_index <= CFG_STOP_DIST;
        cfg_data  <= stop_word;
        do @(posedge clk); while (!cfg_ready);
        stop_limit = stop_word;
        cfg_valid <= 1'b0;
    endtask

    // hold until every ray is taken and every report is in
    task automatic drain();
        do @(posedge clk);
        while (pending_rays.size() != 0 || ray_valid || scan_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic bit [15:0] pick_yaw();
        case ($urandom_range(9))
            0: return YAW_CORNERS[$urandom_range(7)];
            1: return 16'(half_angle);
            2: return 16'(36000 - int'(half_angle));
            3: return 16'(half_angle + 1);
            4: return 16'(36000 + $urandom_range(29535));
            default: return 16'($urandom_range(35999));
        endcase
    endfunction

    function automatic bit [15:0] pick_dist();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return stop_limit + 16'($urandom_range(2)) - 16'd1;
            3: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    // one scan over a small cluster of neighboring labels
    task automatic random_scan(input int rays);
        bit [7:0] base;
        int       span;
        int       k;
        bit       hit;
        base = 8'($urandom_range(255));
        span = $urandom_range(1, 6);
        for (k = 0; k < rays; k++)
        begin
            hit = ($urandom_range(9) != 0);
            queue_ray(base + 8'($urandom_range(span - 1)), pick_yaw(), pick_dist(),
                      hit, k == rays - 1);
            if (hit)
                rays_sent++;
        end
        scans_sent++;
    endtask

    // stimulus
    initial
    begin
        int       p;
        int       k;
        int       ray_mark;
        int       scan_mark;
        bit       paused;
        bit [7:0] sat_label;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        // zero frontal distance replaced, folded yaws, hit-free scan end
        queue_ray(8'd0,   16'd0,     16'd0,     1'b1, 1'b0);
        queue_ray(8'd0,   16'd100,   16'd30,    1'b1, 1'b0);
        queue_ray(8'd255, 16'd35999, 16'hFFFF,  1'b1, 1'b0);
        queue_ray(8'd7,   16'd4500,  16'd30,    1'b1, 1'b0);
        queue_ray(8'd9,   16'd4501,  16'd5,     1'b1, 1'b0);
        queue_ray(8'd3,   16'd36100, 16'd30,    1'b1, 1'b0);
        queue_ray(8'd0,   16'd18000, 16'd0,     1'b0, 1'b1);
        // nothing frontal, then an empty scan
        queue_ray(8'd5,   16'd18000, 16'd10,    1'b1, 1'b1);
        queue_ray(8'd255, 16'hFFFF,  16'hFFFF,  1'b0, 1'b1);
        // equal distances: lower label wins, first ray keeps its yaw
        queue_ray(8'd20,  16'd500,   16'd40,    1'b1, 1'b0);
        queue_ray(8'd10,  16'd600,   16'd40,    1'b1, 1'b0);
        queue_ray(8'd10,  16'd800,   16'd40,    1'b1, 1'b0);
        queue_ray(8'd10,  16'd26000, 16'd40,    1'b1, 1'b0);
        queue_ray(8'd30,  16'd700,   16'd0,     1'b1, 1'b0);
        queue_ray(8'd30,  16'd700,   16'd0,     1'b1, 1'b1);
        // stop limit boundary
        queue_ray(8'd1,   16'd0,     16'd51,    1'b1, 1'b1);
        queue_ray(8'd1,   16'd0,     16'd50,    1'b1, 1'b1);
        rays_sent += 15;
        scans_sent += 6;
        drain();

        for (p = 0; p < 8; p++)
        begin
            set_idling(p % 4);
            case (p)
                0: set_config(16'd0, 16'd0);
                1: set_config(16'd18000, 16'hFFFF);
                2: set_config(16'hFFFF, 16'd100);
                3: set_config(16'd9000, 16'($urandom_range(65535)));
                4: set_config(16'($urandom_range(18000)), 16'($urandom_range(400)));
                5: set_config(16'd17999, 16'd30);
                6: set_config(16'h8000 | 16'd4500, 16'd50);
                default: set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)));
            endcase

            // every ray frontal here: drive both counts into saturation
            if (p == 1)
            begin
                sat_label = 8'($urandom_range(255));
                for (k = 0; k < 365; k++)
                    queue_ray(sat_label, 16'($urandom_range(65535)),
                              16'($urandom_range(1, 1000)), 1'b1, k == 364);
                rays_sent += 365;
                scans_sent++;
            end

            ray_mark  = rays_sent;
            scan_mark = scans_sent;
            paused    = 1'b0;
            while (rays_sent - ray_mark < PHASE_RAYS || scans_sent - scan_mark < 4)
            begin
                case ($urandom_range(15))
                    // lone scan end without a hit
                    0:
                    begin
                        queue_ray(8'($urandom_range(255)), 16'($urandom_range(65535)),
                                  16'($urandom_range(65535)), 1'b0, 1'b1);
                        scans_sent++;
                    end
                    // stray ray without a hit
                    1: queue_ray(8'($urandom_range(255)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 1'b0, 1'b0);
                    default: random_scan($urandom_range(1, 12));
                endcase
                // sender holds off until all reports are in
                if (p == 5 && !paused && rays_sent - ray_mark >= PHASE_RAYS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        $display("run covered %0d hit rays in %0d scans over 9 register settings",
                 rays_sent, scans_sent);
        $display("and four idle mixes, %0d scan reports compared", reports_checked);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
